// ===== rtl/krts_pkg.sv =====
// shared types and constants for the keyed record table core
// no dependencies
package krts_pkg;

    localparam int KEY_W       = 37;
    localparam int NAME_W      = 64;
    localparam int PAY_W       = 32;
    localparam int POS_W       = 6;
    localparam int IDX_OUT_W   = 6;
    localparam int TOTAL_W     = 7;
    localparam int DEF_ENTRIES = 64;

    typedef enum logic [2:0] {
        ACT_ADD    = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_LOOKUP = 3'd2,
        ACT_UPDATE = 3'd3,
        ACT_SORT   = 3'd4,
        ACT_READ   = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_BEYOND    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_SORT,
        S_SORT_END,
        S_READ,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [NAME_W-1:0] name;
        logic [PAY_W-1:0]  pay;
    } rec_t;

endpackage

// ===== rtl/keyed_record_table_with_sort_core.sv =====
// keyed record table: add, remove, lookup, update, bubble sort by name, read at position
// records live in one synchronous memory; depends on krts_pkg
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | action, key, name, payload, flags, position
//   m_      | out       | m_valid / m_ready  | status, index, record, entry total
//
// one item at a time; key search reads one entry per cycle from the record memory,
// stopping at the first hit or after the last entry; remove then copies each later
// entry down one place in the shift-down copy. sort takes count-1 passes, each
// carrying the largest name seen so far to the last position of that pass.
// reset clears control state only; the memory is not cleared. a held result
// stalls the finish of the next item, not its transfer in.
module keyed_record_table_with_sort_core #(
    parameter int ENTRIES = krts_pkg::DEF_ENTRIES
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_action,
    input  logic [krts_pkg::KEY_W-1:0]    s_record_key,
    input  logic [krts_pkg::NAME_W-1:0]   s_name_word,
    input  logic [krts_pkg::PAY_W-1:0]    s_payload_handle,
    input  logic                          s_change_name,
    input  logic                          s_change_payload,
    input  logic [krts_pkg::POS_W-1:0]    s_position,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_status,
    output logic [krts_pkg::IDX_OUT_W-1:0] m_found_index,
    output logic [krts_pkg::KEY_W-1:0]    m_out_key,
    output logic [krts_pkg::NAME_W-1:0]   m_out_name,
    output logic [krts_pkg::PAY_W-1:0]    m_out_payload,
    output logic [krts_pkg::TOTAL_W-1:0]  m_entry_total
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // record memory
    krts_pkg::rec_t mem [ENTRIES];
    krts_pkg::rec_t rd_data_reg;
    logic           rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic           wr_en;
    logic [IDX_W-1:0] wr_addr;
    krts_pkg::rec_t wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control and datapath registers
    krts_pkg::fsm_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;
    logic [IDX_W-1:0] last_reg, last_next;
    krts_pkg::rec_t   carry_reg, carry_next;

    logic [2:0]                  act_reg, act_next;
    logic [krts_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [krts_pkg::NAME_W-1:0] name_reg, name_next;
    logic [krts_pkg::PAY_W-1:0]  pay_reg, pay_next;
    logic                        chgn_reg, chgn_next;
    logic                        chgp_reg, chgp_next;

    krts_pkg::status_t res_status_reg, res_status_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    krts_pkg::rec_t    res_rec_reg, res_rec_next;

    logic                          m_valid_reg, m_valid_next;
    logic [2:0]                    m_status_reg, m_status_next;
    logic [krts_pkg::IDX_OUT_W-1:0] m_idx_reg, m_idx_next;
    krts_pkg::rec_t                m_rec_reg, m_rec_next;
    logic [krts_pkg::TOTAL_W-1:0]  m_total_reg, m_total_next;

    logic           accept;
    logic           scan_hit;
    logic           scan_over;
    logic           sort_over;
    logic           read_ok;
    logic           out_free;
    krts_pkg::rec_t upd_rec;
    krts_pkg::rec_t new_rec;

    assign s_ready   = (state_reg == krts_pkg::S_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign scan_hit  = pend_reg && (rd_data_reg.key == key_reg);
    assign scan_over = !pend_reg && (iss_reg >= cnt_reg);
    assign sort_over = !pend_reg && (iss_reg > CNT_W'(last_reg));
    assign read_ok   = (s_position < cnt_reg) && (s_position < ENTRIES);

    assign new_rec = '{key: key_reg, name: name_reg, pay: pay_reg};

    always_comb begin
        upd_rec = rd_data_reg;
        if (chgn_reg) begin
            upd_rec.name = name_reg;
        end
        if (chgp_reg) begin
            upd_rec.pay = pay_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            krts_pkg::S_IDLE: begin
                if (accept) begin
                    case (s_action)
                        krts_pkg::ACT_ADD, krts_pkg::ACT_REMOVE,
                        krts_pkg::ACT_LOOKUP, krts_pkg::ACT_UPDATE: begin
                            state_next = krts_pkg::S_SCAN;
                        end
                        krts_pkg::ACT_SORT: begin
                            state_next = (cnt_reg > CNT_W'(1)) ? krts_pkg::S_SORT
                                                               : krts_pkg::S_DONE;
                        end
                        krts_pkg::ACT_READ: begin
                            state_next = read_ok ? krts_pkg::S_READ : krts_pkg::S_DONE;
                        end
                        default: begin
                            state_next = krts_pkg::S_DONE;
                        end
                    endcase
                end
            end
            krts_pkg::S_SCAN: begin
                if (scan_hit) begin
                    state_next = (act_reg == krts_pkg::ACT_REMOVE) ? krts_pkg::S_SHIFT
                                                                   : krts_pkg::S_DONE;
                end else if (scan_over) begin
                    state_next = krts_pkg::S_DONE;
                end
            end
            krts_pkg::S_SHIFT: begin
                if (scan_over) begin
                    state_next = krts_pkg::S_DONE;
                end
            end
            krts_pkg::S_SORT: begin
                if (sort_over) begin
                    state_next = krts_pkg::S_SORT_END;
                end
            end
            krts_pkg::S_SORT_END: begin
                state_next = (last_reg == IDX_W'(1)) ? krts_pkg::S_DONE : krts_pkg::S_SORT;
            end
            krts_pkg::S_READ: begin
                state_next = krts_pkg::S_DONE;
            end
            krts_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = krts_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = krts_pkg::S_IDLE;
            end
        endcase
    end

    // datapath, memory ports and result
    always_comb begin
        cnt_next        = cnt_reg;
        iss_next        = iss_reg;
        pend_next       = 1'b0;
        pidx_next       = pidx_reg;
        last_next       = last_reg;
        carry_next      = carry_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        name_next       = name_reg;
        pay_next        = pay_reg;
        chgn_next       = chgn_reg;
        chgp_next       = chgp_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_rec_next    = res_rec_reg;
        rd_en           = 1'b0;
        rd_addr         = iss_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = pidx_reg - IDX_W'(1);
        wr_data         = rd_data_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_idx_next    = m_idx_reg;
        m_rec_next    = m_rec_reg;
        m_total_next  = m_total_reg;

        case (state_reg)
            krts_pkg::S_IDLE: begin
                if (accept) begin
                    act_next        = s_action;
                    key_next        = s_record_key;
                    name_next       = s_name_word;
                    pay_next        = s_payload_handle;
                    chgn_next       = s_change_name;
                    chgp_next       = s_change_payload;
                    iss_next        = '0;
                    last_next       = IDX_W'(cnt_reg - CNT_W'(1));
                    res_status_next = krts_pkg::ST_OK;
                    res_idx_next    = '0;
                    res_rec_next    = '0;
                    if (s_action == krts_pkg::ACT_READ) begin
                        if (read_ok) begin
                            rd_en        = 1'b1;
                            rd_addr      = IDX_W'(s_position);
                            res_idx_next = IDX_W'(s_position);
                        end else begin
                            res_status_next = krts_pkg::ST_BEYOND;
                        end
                    end
                end
            end
            krts_pkg::S_SCAN: begin
                // one read issued per cycle, compare on the data of the previous one
                rd_en     = (iss_reg < cnt_reg);
                pend_next = rd_en;
                if (rd_en) begin
                    iss_next  = iss_reg + CNT_W'(1);
                    pidx_next = iss_reg[IDX_W-1:0];
                end
                if (scan_hit) begin
                    res_idx_next = pidx_reg;
                    res_rec_next = rd_data_reg;
                    case (act_reg)
                        krts_pkg::ACT_ADD: begin
                            res_status_next = krts_pkg::ST_DUPLICATE;
                        end
                        krts_pkg::ACT_REMOVE: begin
                            // start the shift-down copy just past the removed entry
                            rd_en     = 1'b0;
                            pend_next = 1'b0;
                            iss_next  = CNT_W'(pidx_reg) + CNT_W'(1);
                        end
                        krts_pkg::ACT_UPDATE: begin
                            wr_en        = 1'b1;
                            wr_addr      = pidx_reg;
                            wr_data      = upd_rec;
                            res_rec_next = upd_rec;
                        end
                        default: begin
                        end
                    endcase
                end else if (scan_over) begin
                    if (act_reg == krts_pkg::ACT_ADD) begin
                        if (cnt_reg >= ENTRIES) begin
                            res_status_next = krts_pkg::ST_FULL;
                        end else begin
                            wr_en        = 1'b1;
                            wr_addr      = cnt_reg[IDX_W-1:0];
                            wr_data      = new_rec;
                            res_idx_next = cnt_reg[IDX_W-1:0];
                            res_rec_next = new_rec;
                            cnt_next     = cnt_reg + CNT_W'(1);
                        end
                    end else begin
                        res_status_next = krts_pkg::ST_NOT_FOUND;
                    end
                end
            end
            krts_pkg::S_SHIFT: begin
                rd_en     = (iss_reg < cnt_reg);
                pend_next = rd_en;
                if (rd_en) begin
                    iss_next  = iss_reg + CNT_W'(1);
                    pidx_next = iss_reg[IDX_W-1:0];
                end
                if (pend_reg) begin
                    wr_en = 1'b1;
                end
                if (scan_over) begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            krts_pkg::S_SORT: begin
                // the carry holds the largest name seen so far in this pass
                rd_en     = (iss_reg <= CNT_W'(last_reg));
                pend_next = rd_en;
                if (rd_en) begin
                    iss_next  = iss_reg + CNT_W'(1);
                    pidx_next = iss_reg[IDX_W-1:0];
                end
                if (pend_reg) begin
                    if (pidx_reg == '0) begin
                        carry_next = rd_data_reg;
                    end else begin
                        wr_en = 1'b1;
                        if (carry_reg.name > rd_data_reg.name) begin
                            wr_data = rd_data_reg;
                        end else begin
                            wr_data    = carry_reg;
                            carry_next = rd_data_reg;
                        end
                    end
                end
            end
            krts_pkg::S_SORT_END: begin
                wr_en     = 1'b1;
                wr_addr   = last_reg;
                wr_data   = carry_reg;
                last_next = last_reg - IDX_W'(1);
                iss_next  = '0;
            end
            krts_pkg::S_READ: begin
                res_rec_next = rd_data_reg;
            end
            krts_pkg::S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_idx_next    = krts_pkg::IDX_OUT_W'(res_idx_reg);
                    m_rec_next    = res_rec_reg;
                    m_total_next  = krts_pkg::TOTAL_W'(cnt_reg);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= krts_pkg::S_IDLE;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        iss_reg        <= iss_next;
        pidx_reg       <= pidx_next;
        last_reg       <= last_next;
        carry_reg      <= carry_next;
        act_reg        <= act_next;
        key_reg        <= key_next;
        name_reg       <= name_next;
        pay_reg        <= pay_next;
        chgn_reg       <= chgn_next;
        chgp_reg       <= chgp_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_rec_reg    <= res_rec_next;
        m_status_reg   <= m_status_next;
        m_idx_reg      <= m_idx_next;
        m_rec_reg      <= m_rec_next;
        m_total_reg    <= m_total_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_index = m_idx_reg;
    assign m_out_key     = m_rec_reg.key;
    assign m_out_name    = m_rec_reg.name;
    assign m_out_payload = m_rec_reg.pay;
    assign m_entry_total = m_total_reg;

endmodule
